// ===== hdl/working_set_thrashing_control_macros.svh =====
// ----------------------------------------------------------------------------
// working set thrashing control assertion macros
// concurrent assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef WORKING_SET_THRASHING_CONTROL_MACROS_SVH
`define WORKING_SET_THRASHING_CONTROL_MACROS_SVH

// same-cycle implication
`define WSTC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define WSTC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/wstc_pkg.sv =====
// ----------------------------------------------------------------------------
// wstc_pkg
// types and constants of the working set thrashing control block
// ----------------------------------------------------------------------------
package wstc_pkg;

  localparam int unsigned PID_W   = 6;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CD_W    = 16;
  localparam int unsigned TOT_W   = 38;
  localparam int unsigned FREE_W  = 32;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned ACT_W   = 3;

  localparam logic [CD_W-1:0]  SLEEP_TICKS_RST = 16'd200;
  localparam logic [CNT_W-1:0] COUNT_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_COUNT   = 3'd1,
    ACT_MARK    = 3'd2,
    ACT_END     = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_QUERY   = 3'd5,
    ACT_UNBLOCK = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_VICTIM,
    ST_TICK,
    ST_TICK_OUT
  } state_e;

  typedef struct packed {
    logic              new_traced;
    logic              thrashing;
    logic [PID_W-1:0]  victim_id;
    logic              victim_blocked;
    logic [MASK_W-1:0] expired_mask;
    logic [CD_W-1:0]   remaining_ticks;
    logic              last;
  } out_beat_t;

endpackage

// ===== hdl/wstc_ram.sv =====
// ----------------------------------------------------------------------------
// wstc_ram
// one write port, one read port memory with registered read data
// ----------------------------------------------------------------------------
module wstc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/working_set_thrashing_control.sv =====
// ----------------------------------------------------------------------------
// working_set_thrashing_control
// working-set counting, thrashing victim selection and block countdowns
// ----------------------------------------------------------------------------
// Start, count entry, mark entry, query, unblock and unused actions are
// accepted and then finished after one memory read. A tick sweeps every process
// slot through the countdown memory. An end of pass without thrashing finishes
// after the same read; with thrashing each victim costs a full argmax sweep of
// the count memory through one shared comparator. Both stores are cleared by
// per-slot valid flags, so there is no clearing pass after reset. Input is
// taken only while the sequencer is idle; a finished result waits in the
// output register, and a stalled output stalls the sequencer only where it has
// a result to hand over.
// ----------------------------------------------------------------------------
module working_set_thrashing_control #(
  parameter int unsigned PROCESSES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [wstc_pkg::CD_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [wstc_pkg::ACT_W-1:0]  action_i,
  input  logic [wstc_pkg::PID_W-1:0]  process_id_i,
  input  logic                        entry_valid_i,
  input  logic                        entry_swapped_i,
  input  logic                        entry_accessed_i,
  input  logic                        entry_traced_i,
  input  logic                        table_ready_i,
  input  logic [wstc_pkg::FREE_W-1:0] free_frames_i,
  input  logic [wstc_pkg::MASK_W-1:0] zombie_mask_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        new_traced_o,
  output logic                        thrashing_o,
  output logic [wstc_pkg::PID_W-1:0]  victim_id_o,
  output logic                        victim_blocked_o,
  output logic [wstc_pkg::MASK_W-1:0] expired_mask_o,
  output logic [wstc_pkg::CD_W-1:0]   remaining_ticks_o,
  output logic                        last_o
);

  import wstc_pkg::*;

  localparam int unsigned IW = $clog2(PROCESSES);
  localparam logic [IW:0] SLOT_END  = (IW+1)'(PROCESSES);
  localparam logic [IW:0] VIC_LAST  = (IW+1)'(PROCESSES - 1);
  localparam logic [PID_W:0] PID_END = (PID_W+1)'(PROCESSES);

  state_e state_q, state_d;

  // latched input beat
  action_e           act_q;
  logic [PID_W-1:0]  pid_q;
  logic              ev_q, es_q, ea_q, et_q, tr_q;
  logic [FREE_W-1:0] free_q;
  logic [MASK_W-1:0] zombie_q;

  logic [CD_W-1:0]      sleep_ticks_q;
  logic [TOT_W-1:0]     total_q;
  logic [PROCESSES-1:0] cnt_vld_q, cd_vld_q;

  logic [IW:0]      scan_q, nvic_q;
  logic             rd_pend_q;
  logic [IW-1:0]    rd_idx_q;
  logic [CNT_W-1:0] best_val_q;
  logic [IW-1:0]    best_idx_q;
  logic [MASK_W-1:0] exp_q;

  out_beat_t out_q, beat;
  logic      out_valid_q, emit, out_free;

  // memory ports
  logic             cnt_we, cnt_re, cd_we, cd_re;
  logic [IW-1:0]    cnt_waddr, cnt_raddr, cd_waddr, cd_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic [CD_W-1:0]  cd_wdata, cd_rdata;

  // sequencer strobes
  logic in_acc, clr_counts, total_inc, scan_start, scan_rd, take_victim, cd_clr;

  // datapath values
  logic [IW-1:0]    idx;
  logic             pid_ok, free_slot, count_hit, mark_hit, total_gt, vic_last;
  logic             vic_block;
  logic [CNT_W-1:0] cnt_cur, scan_val;
  logic [CD_W-1:0]  cd_cur, tick_val;
  logic [TOT_W-1:0] total_after;

  wstc_ram #(.DEPTH(PROCESSES), .WIDTH(CNT_W)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  wstc_ram #(.DEPTH(PROCESSES), .WIDTH(CD_W)) u_cd_ram (
    .clk_i   (clk_i),
    .we_i    (cd_we),
    .waddr_i (cd_waddr),
    .wdata_i (cd_wdata),
    .re_i    (cd_re),
    .raddr_i (cd_raddr),
    .rdata_o (cd_rdata)
  );

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  assign idx       = pid_q[IW-1:0];
  assign pid_ok    = {1'b0, pid_q} < PID_END;
  assign cnt_cur   = cnt_vld_q[idx] ? cnt_rdata : '0;
  assign cd_cur    = cd_vld_q[idx] ? cd_rdata : '0;
  assign free_slot = pid_ok && (cd_cur == '0);
  assign count_hit = free_slot && (ev_q || es_q) && et_q;
  assign mark_hit  = free_slot && tr_q && !et_q && (ev_q || es_q) && ea_q;
  assign total_gt  = total_q > {{(TOT_W-FREE_W){1'b0}}, free_q};

  // shared comparator operands
  assign scan_val    = cnt_vld_q[rd_idx_q] ? cnt_rdata : '0;
  assign tick_val    = cd_vld_q[rd_idx_q] ? cd_rdata : '0;
  assign total_after = total_q - {{(TOT_W-CNT_W){1'b0}}, best_val_q};
  assign vic_last    = !(total_after > {{(TOT_W-FREE_W){1'b0}}, free_q})
                       || (nvic_q == VIC_LAST);
  assign vic_block   = !zombie_q[best_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    emit        = 1'b0;
    beat        = '0;
    beat.last   = 1'b1;
    cnt_we      = 1'b0;
    cnt_waddr   = idx;
    cnt_wdata   = cnt_cur + 1'b1;
    cnt_re      = 1'b0;
    cnt_raddr   = process_id_i[IW-1:0];
    cd_we       = 1'b0;
    cd_waddr    = rd_idx_q;
    cd_wdata    = tick_val - 1'b1;
    cd_re       = 1'b0;
    cd_raddr    = process_id_i[IW-1:0];
    clr_counts  = 1'b0;
    total_inc   = 1'b0;
    scan_start  = 1'b0;
    scan_rd     = 1'b0;
    take_victim = 1'b0;
    cd_clr      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_re  = 1'b1;
          cd_re   = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (act_q)
          ACT_END: begin
            if (total_gt) begin
              scan_start = 1'b1;
              state_d    = ST_SCAN;
            end else if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
          ACT_TICK: begin
            scan_start = 1'b1;
            state_d    = ST_TICK;
          end
          default: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              case (act_q)
                ACT_START: clr_counts = 1'b1;
                ACT_COUNT: begin
                  beat.new_traced = count_hit ? 1'b0 : et_q;
                  if (count_hit && (cnt_cur != COUNT_MAX)) begin
                    cnt_we    = 1'b1;
                    total_inc = 1'b1;
                  end
                end
                ACT_MARK:    beat.new_traced = mark_hit || et_q;
                ACT_QUERY:   beat.remaining_ticks = pid_ok ? cd_cur : '0;
                ACT_UNBLOCK: cd_clr = pid_ok;
                default: ;
              endcase
            end
          end
        endcase
      end
      ST_SCAN: begin
        cnt_raddr = scan_q[IW-1:0];
        if (scan_q != SLOT_END) begin
          cnt_re  = 1'b1;
          scan_rd = 1'b1;
        end else begin
          state_d = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (out_free) begin
          emit                = 1'b1;
          take_victim         = 1'b1;
          beat.thrashing      = 1'b1;
          beat.victim_id      = PID_W'(best_idx_q);
          beat.victim_blocked = vic_block;
          beat.last           = vic_last;
          cd_we               = vic_block;
          cd_waddr            = best_idx_q;
          cd_wdata            = sleep_ticks_q;
          if (vic_last) begin
            state_d = ST_IDLE;
          end else begin
            scan_start = 1'b1;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_TICK: begin
        cd_raddr = scan_q[IW-1:0];
        if (scan_q != SLOT_END) begin
          cd_re   = 1'b1;
          scan_rd = 1'b1;
        end else begin
          state_d = ST_TICK_OUT;
        end
        if (rd_pend_q && (tick_val != '0)) begin
          cd_we = 1'b1;
        end
      end
      ST_TICK_OUT: begin
        if (out_free) begin
          emit              = 1'b1;
          beat.expired_mask = exp_q;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // input beat capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= action_e'(action_i);
      pid_q    <= process_id_i;
      ev_q     <= entry_valid_i;
      es_q     <= entry_swapped_i;
      ea_q     <= entry_accessed_i;
      et_q     <= entry_traced_i;
      tr_q     <= table_ready_i;
      free_q   <= free_frames_i;
      zombie_q <= zombie_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_ticks_q <= SLEEP_TICKS_RST;
    end else if (cfg_we_i) begin
      sleep_ticks_q <= cfg_wdata_i;
    end
  end

  // running total and slot valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      cnt_vld_q <= '0;
      cd_vld_q  <= '0;
    end else begin
      if (clr_counts) begin
        total_q   <= '0;
        cnt_vld_q <= '0;
      end else if (total_inc) begin
        total_q <= total_q + 1'b1;
      end else if (take_victim) begin
        total_q               <= total_after;
        cnt_vld_q[best_idx_q] <= 1'b0;
      end
      if (cnt_we) begin
        cnt_vld_q[cnt_waddr] <= 1'b1;
      end
      if (cd_we) begin
        cd_vld_q[cd_waddr] <= 1'b1;
      end else if (cd_clr) begin
        cd_vld_q[idx] <= 1'b0;
      end
    end
  end

  // sweep counter and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= '0;
      nvic_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= scan_rd;
      if (scan_start) begin
        scan_q <= '0;
      end else if (scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (in_acc) begin
        nvic_q <= '0;
      end else if (take_victim) begin
        nvic_q <= nvic_q + 1'b1;
      end
    end
  end

  // argmax and expiry accumulation
  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      rd_idx_q <= scan_q[IW-1:0];
    end
    if (rd_pend_q && (state_q == ST_SCAN)) begin
      if ((rd_idx_q == '0) || (scan_val > best_val_q)) begin
        best_val_q <= scan_val;
        best_idx_q <= rd_idx_q;
      end
    end
    if (scan_start && (act_q == ACT_TICK)) begin
      exp_q <= '0;
    end else if (rd_pend_q && (state_q == ST_TICK) && (tick_val == CD_W'(1))) begin
      exp_q[rd_idx_q] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= beat;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign new_traced_o      = out_q.new_traced;
  assign thrashing_o       = out_q.thrashing;
  assign victim_id_o       = out_q.victim_id;
  assign victim_blocked_o  = out_q.victim_blocked;
  assign expired_mask_o    = out_q.expired_mask;
  assign remaining_ticks_o = out_q.remaining_ticks;
  assign last_o            = out_q.last;

endmodule

// ===== hdl/wstc_checker.sv =====
// ----------------------------------------------------------------------------
// wstc_checker
// port-level checks of the working set thrashing control block
// ----------------------------------------------------------------------------
`include "working_set_thrashing_control_macros.svh"

module wstc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       thrashing_o,
  input logic [wstc_pkg::PID_W-1:0] victim_id_o,
  input logic                       victim_blocked_o,
  input logic                       last_o
);

  // one beat in flight at a time
  `WSTC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // only a victim beat can be followed by more beats of the same item
  `WSTC_ASSERT_IMP(a_more_only_victims, clk_i, rst_ni, out_valid_o && !last_o, thrashing_o)

  // no victim fields without thrashing
  `WSTC_ASSERT_IMP(a_victim_needs_thrash, clk_i, rst_ni, out_valid_o && !thrashing_o, (victim_id_o == '0) && !victim_blocked_o)

  // a stalled beat holds
  `WSTC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(last_o) && $stable(victim_id_o))

endmodule

bind working_set_thrashing_control wstc_checker u_wstc_checker (.*);
